### rtl/msa_pkg.sv
// ----------------------------------------------------------------------------
// Median of two sorted arrays: shared package
// Command and result beat types, function and status codes, default depth.
// ----------------------------------------------------------------------------
`default_nettype none

package msa_pkg;

  localparam int unsigned ARRAY_DEPTH = 1024;

  localparam logic [1:0] FUNC_LOAD_FIRST  = 2'd0;
  localparam logic [1:0] FUNC_LOAD_SECOND = 2'd1;
  localparam logic [1:0] FUNC_COMPUTE     = 2'd2;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_EMPTY    = 2'd1;
  localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [31:0] value;
  } cmd_t;

  typedef struct packed {
    logic signed [32:0] median_doubled;
    logic [1:0]         status;
  } res_t;

endpackage

`default_nettype wire

### rtl/median_of_two_sorted_arrays_unit.sv
// ----------------------------------------------------------------------------
// Median of two sorted arrays
// Loads two ascending arrays into two memories and finds twice the median of
// their union with an iterative halving k-th smallest element search.
// ----------------------------------------------------------------------------
// Usage: a command beat on cmd_i is taken at a rising edge where start_i is
// high and busy_o is low. A load beat appends cmd_i.value to the first or
// second memory and gives no result; busy_o stays low, so loads run back to
// back. A load into a full memory is dropped and remembered. A compute beat
// on a non-empty union raises busy_o while one search engine reads both
// memories in parallel, one read per memory per step. Each step is an
// address and registered read, then a compare and update; a search for the
// k-th element takes one step per halving and one final pick. An even total
// runs two searches. The result beat follows in the cycle after the last
// step, with busy_o already low; an empty union answers in the cycle after
// the compute beat. The result is shown on res_o for exactly one cycle with
// done_o high; the receiver cannot stall it. After a compute both arrays are
// empty again. Reset empties both arrays and clears the overflow record;
// memory contents are left as they are, and words beyond the fill counts
// may be read but are never used.
// ----------------------------------------------------------------------------
`default_nettype none

module median_of_two_sorted_arrays_unit #(
  parameter int unsigned ARRAY_DEPTH = msa_pkg::ARRAY_DEPTH
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire msa_pkg::cmd_t cmd_i,
  output logic               busy_o,
  output logic               done_o,
  output msa_pkg::res_t      res_o
);

  localparam int unsigned CW = $clog2(ARRAY_DEPTH + 1);
  localparam int unsigned KW = CW + 2;
  localparam int unsigned AW = (ARRAY_DEPTH > 1) ? $clog2(ARRAY_DEPTH) : 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(ARRAY_DEPTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_STEP,
    S_EVAL
  } state_e;

  typedef enum logic [1:0] {
    M_HALVE,
    M_PICK_FIRST,
    M_PICK_SECOND,
    M_MIN
  } mode_e;

  logic signed [31:0] first_mem  [ARRAY_DEPTH];
  logic signed [31:0] second_mem [ARRAY_DEPTH];

  state_e             state_q;
  mode_e              mode_q;
  logic [CW-1:0]      first_cnt_q, second_cnt_q;
  logic               overflow_q;
  logic [KW-1:0]      a_q, b_q, k_q;
  logic               in_a_q, in_b_q;
  logic               odd_q, second_pass_q;
  logic [KW-1:0]      k_next_q;
  logic signed [32:0] sum_q;
  logic signed [31:0] rd_first_q, rd_second_q;
  logic               done_q;
  msa_pkg::res_t      res_q;

  logic               accept;
  logic               load_first, load_second;
  logic [KW-1:0]      m_w, n_w, total_w, half_w, off_w;
  logic               ge_a, ge_b, k_one;
  logic [KW-1:0]      addr_first_w, addr_second_w;
  mode_e              mode_w;
  logic               take_a;
  logic signed [31:0] pick_w;
  logic signed [32:0] pick_ext, final_w;

  assign accept      = start_i && !busy_o;
  assign load_first  = accept && (cmd_i.func == msa_pkg::FUNC_LOAD_FIRST);
  assign load_second = accept && (cmd_i.func == msa_pkg::FUNC_LOAD_SECOND);

  assign m_w     = KW'(first_cnt_q);
  assign n_w     = KW'(second_cnt_q);
  assign total_w = m_w + n_w;
  assign half_w  = k_q >> 1;
  assign off_w   = half_w - KW'(1);
  assign ge_a    = a_q >= m_w;
  assign ge_b    = b_q >= n_w;
  assign k_one   = k_q == KW'(1);

  always_comb begin
    if (ge_a) begin
      mode_w = M_PICK_SECOND;
    end else if (ge_b) begin
      mode_w = M_PICK_FIRST;
    end else if (k_one) begin
      mode_w = M_MIN;
    end else begin
      mode_w = M_HALVE;
    end
  end

  always_comb begin
    case (mode_w)
      M_PICK_FIRST: begin
        addr_first_w  = a_q + k_q - KW'(1);
        addr_second_w = b_q;
      end
      M_PICK_SECOND: begin
        addr_first_w  = a_q;
        addr_second_w = b_q + k_q - KW'(1);
      end
      M_MIN: begin
        addr_first_w  = a_q;
        addr_second_w = b_q;
      end
      default: begin
        addr_first_w  = a_q + off_w;
        addr_second_w = b_q + off_w;
      end
    endcase
  end

  always_comb begin
    if (in_a_q && in_b_q) begin
      take_a = rd_first_q < rd_second_q;
    end else begin
      take_a = in_a_q;
    end
  end

  always_comb begin
    case (mode_q)
      M_PICK_FIRST:  pick_w = rd_first_q;
      M_PICK_SECOND: pick_w = rd_second_q;
      default:       pick_w = (rd_first_q < rd_second_q) ? rd_first_q : rd_second_q;
    endcase
  end

  assign pick_ext = {pick_w[31], pick_w};
  assign final_w  = odd_q ? (pick_ext <<< 1) : (sum_q + pick_ext);

  always_ff @(posedge clk_i) begin
    if (load_first && (first_cnt_q < DEPTH_C)) begin
      first_mem[first_cnt_q[AW-1:0]] <= cmd_i.value;
    end
    if (state_q == S_STEP) begin
      rd_first_q <= first_mem[addr_first_w[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_second && (second_cnt_q < DEPTH_C)) begin
      second_mem[second_cnt_q[AW-1:0]] <= cmd_i.value;
    end
    if (state_q == S_STEP) begin
      rd_second_q <= second_mem[addr_second_w[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      mode_q        <= M_HALVE;
      first_cnt_q   <= '0;
      second_cnt_q  <= '0;
      overflow_q    <= 1'b0;
      a_q           <= '0;
      b_q           <= '0;
      k_q           <= '0;
      in_a_q        <= 1'b0;
      in_b_q        <= 1'b0;
      odd_q         <= 1'b0;
      second_pass_q <= 1'b0;
      k_next_q      <= '0;
      sum_q         <= '0;
      done_q        <= 1'b0;
      res_q         <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (load_first) begin
            if (first_cnt_q < DEPTH_C) begin
              first_cnt_q <= first_cnt_q + CW'(1);
            end else begin
              overflow_q <= 1'b1;
            end
          end
          if (load_second) begin
            if (second_cnt_q < DEPTH_C) begin
              second_cnt_q <= second_cnt_q + CW'(1);
            end else begin
              overflow_q <= 1'b1;
            end
          end
          if (accept && (cmd_i.func == msa_pkg::FUNC_COMPUTE)) begin
            if (total_w == '0) begin
              done_q               <= 1'b1;
              res_q.median_doubled <= '0;
              res_q.status         <= msa_pkg::STATUS_EMPTY;
              overflow_q           <= 1'b0;
            end else begin
              a_q           <= '0;
              b_q           <= '0;
              odd_q         <= total_w[0];
              second_pass_q <= 1'b0;
              k_next_q      <= (total_w >> 1) + KW'(1);
              k_q           <= total_w[0] ? ((total_w >> 1) + KW'(1)) : (total_w >> 1);
              state_q       <= S_STEP;
            end
          end
        end
        S_STEP: begin
          mode_q  <= mode_w;
          in_a_q  <= (a_q + off_w) < m_w;
          in_b_q  <= (b_q + off_w) < n_w;
          state_q <= S_EVAL;
        end
        S_EVAL: begin
          if (mode_q == M_HALVE) begin
            if (take_a) begin
              a_q <= a_q + half_w;
            end else begin
              b_q <= b_q + half_w;
            end
            k_q     <= k_q - half_w;
            state_q <= S_STEP;
          end else if (!odd_q && !second_pass_q) begin
            sum_q         <= pick_ext;
            second_pass_q <= 1'b1;
            a_q           <= '0;
            b_q           <= '0;
            k_q           <= k_next_q;
            state_q       <= S_STEP;
          end else begin
            done_q               <= 1'b1;
            res_q.median_doubled <= final_w;
            res_q.status         <= overflow_q ? msa_pkg::STATUS_OVERFLOW
                                               : msa_pkg::STATUS_OK;
            first_cnt_q          <= '0;
            second_cnt_q         <= '0;
            overflow_q           <= 1'b0;
            state_q              <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;
  assign res_o  = res_q;

`ifndef ASSERT_OFF
  a_done_not_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result beat shown while the search is still running");

  a_empty_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (res_o.status == msa_pkg::STATUS_EMPTY)) |-> (res_o.median_doubled == '0))
    else $error("empty union gave a non-zero median");

  a_cursor_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> ((a_q <= m_w) && (b_q <= n_w)))
    else $error("search cursor ran past the fill count");

  a_compute_starts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (cmd_i.func == msa_pkg::FUNC_COMPUTE)) |=> (busy_o || done_o))
    else $error("compute beat neither started a search nor answered");

  a_counts_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ((first_cnt_q == '0) && (second_cnt_q == '0) && !overflow_q))
    else $error("arrays not emptied after a compute");
`endif

endmodule

`default_nettype wire

### dv/tb.sv
// ----------------------------------------------------------------------------
// Testbench for the median of two sorted arrays unit
// Loads sorted arrays of random size and content into both memories, issues
// compute beats and checks every result beat against an in-bench model of the
// halving k-th smallest search. The run covers empty unions, extreme values,
// unsorted data, ignored selectors and a full memory overflowing on one side.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0]  FUNC_UNUSED  = 2'd3;
  localparam int unsigned TOTAL_ITEMS  = 1600;
  localparam int unsigned QUIET_FROM   = 1400;
  localparam int unsigned CYCLE_LIMIT  = 500000;

  typedef enum int unsigned {
    SPREAD_FULL,
    SPREAD_NARROW,
    SPREAD_EXTREME,
    SPREAD_CLUSTER
  } spread_e;

  class median_scoreboard;
    bit signed [31:0]  first_mem [msa_pkg::ARRAY_DEPTH];
    bit signed [31:0]  second_mem [msa_pkg::ARRAY_DEPTH];
    int unsigned       first_len;
    int unsigned       second_len;
    bit                dropped_load;
    msa_pkg::res_t     expected_medians [$];
    int unsigned       mismatch_count;

    function longint kth_of_union(int unsigned k);
      int unsigned a;
      int unsigned b;
      int unsigned half;
      int unsigned off;
      bit          found;
      bit          take_first;
      longint      kth;
      a = 0;
      b = 0;
      found = 1'b0;
      kth = 0;
      while (!found) begin
        if (a >= first_len) begin
          kth = second_mem[b + k - 1];
          found = 1'b1;
        end else if (b >= second_len) begin
          kth = first_mem[a + k - 1];
          found = 1'b1;
        end else if (k == 1) begin
          kth = (first_mem[a] < second_mem[b]) ? first_mem[a] : second_mem[b];
          found = 1'b1;
        end else begin
          half = k / 2;
          off = half - 1;
          if (a + off < first_len && b + off < second_len) begin
            take_first = first_mem[a + off] < second_mem[b + off];
          end else begin
            take_first = (a + off < first_len);
          end
          if (take_first) begin
            a += half;
          end else begin
            b += half;
          end
          k -= half;
        end
      end
      return kth;
    endfunction

    function void note_command(msa_pkg::cmd_t cmd);
      int unsigned   total;
      longint        twice;
      msa_pkg::res_t median;
      case (cmd.func)
        msa_pkg::FUNC_LOAD_FIRST: begin
          if (first_len < msa_pkg::ARRAY_DEPTH) begin
            first_mem[first_len] = cmd.value;
            first_len++;
          end else begin
            dropped_load = 1'b1;
          end
        end
        msa_pkg::FUNC_LOAD_SECOND: begin
          if (second_len < msa_pkg::ARRAY_DEPTH) begin
            second_mem[second_len] = cmd.value;
            second_len++;
          end else begin
            dropped_load = 1'b1;
          end
        end
        msa_pkg::FUNC_COMPUTE: begin
          total = first_len + second_len;
          twice = 0;
          median.status = msa_pkg::STATUS_EMPTY;
          if (total != 0) begin
            if (total % 2 == 1) begin
              twice = 2 * kth_of_union(total / 2 + 1);
            end else begin
              twice = kth_of_union(total / 2) + kth_of_union(total / 2 + 1);
            end
            median.status = dropped_load ? msa_pkg::STATUS_OVERFLOW : msa_pkg::STATUS_OK;
          end
          median.median_doubled = twice[32:0];
          expected_medians.push_back(median);
          first_len = 0;
          second_len = 0;
          dropped_load = 1'b0;
        end
        default: begin
        end
      endcase
    endfunction

    task report(string what);
      mismatch_count++;
      $display("ERROR at %0t ns: %s", $time, what);
    endtask

    task check_result(msa_pkg::res_t got);
      msa_pkg::res_t want;
      if (expected_medians.size() == 0) begin
        report($sformatf("result beat with no compute outstanding: %0d, status %0d",
                         got.median_doubled, got.status));
      end else begin
        want = expected_medians.pop_front();
        if (got.median_doubled !== want.median_doubled) begin
          report($sformatf("median_doubled is %0d, expected %0d",
                           got.median_doubled, want.median_doubled));
        end
        if (got.status !== want.status) begin
          report($sformatf("status is %0d, expected %0d", got.status, want.status));
        end
      end
    endtask
  endclass

  logic          clk_i;
  logic          rst_ni;
  logic          start_i;
  msa_pkg::cmd_t cmd_i;
  logic          busy_o;
  logic          done_o;
  msa_pkg::res_t res_o;

  median_scoreboard sb;
  int unsigned      items_sent;
  int unsigned      idle_pct;
  bit               quiet;
  bit               full_done;
  int unsigned      cycle_count = 0;

  median_of_two_sorted_arrays_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .cmd_i  (cmd_i),
    .busy_o (busy_o),
    .done_o (done_o),
    .res_o  (res_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("ERROR: run did not complete within %0d cycles", CYCLE_LIMIT);
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      sb.check_result(res_o);
    end
  end

  task automatic idle_gap(int unsigned cycles);
    repeat (cycles) begin
      @(negedge clk_i);
      start_i = 1'b0;
      cmd_i.func = 2'($urandom);
      cmd_i.value = $urandom;
    end
  endtask

  task automatic send(msa_pkg::cmd_t cmd);
    if (!quiet && $urandom_range(99) < idle_pct) begin
      idle_gap($urandom_range(1, 15));
    end
    @(negedge clk_i);
    start_i = 1'b1;
    cmd_i = cmd;
    do @(posedge clk_i); while (busy_o);
    sb.note_command(cmd);
    if (cmd.func != FUNC_UNUSED) begin
      items_sent++;
    end
    quiet = (items_sent >= QUIET_FROM);
  endtask

  task automatic load(logic [1:0] func, int value);
    msa_pkg::cmd_t cmd;
    cmd.func = func;
    cmd.value = value;
    send(cmd);
  endtask

  function automatic int pick_value(spread_e spread);
    case (spread)
      SPREAD_FULL: begin
        return $urandom;
      end
      SPREAD_NARROW: begin
        return int'($urandom_range(20)) - 10;
      end
      SPREAD_EXTREME: begin
        if ($urandom_range(1)) begin
          return 32'sh8000_0000 + int'($urandom_range(3));
        end
        return 32'sh7fff_ffff - int'($urandom_range(3));
      end
      default: begin
        return int'($urandom_range(3)) * 1000;
      end
    endcase
  endfunction

  task automatic run_set(int unsigned n_first, int unsigned n_second, bit sorted);
    int      first_q [$];
    int      second_q [$];
    spread_e spread;
    spread = spread_e'($urandom_range(3));
    repeat (n_first) first_q.push_back(pick_value(spread));
    repeat (n_second) second_q.push_back(pick_value(spread));
    if (sorted) begin
      first_q.sort();
      second_q.sort();
    end
    while (first_q.size() + second_q.size() != 0) begin
      if ($urandom_range(19) == 0) begin
        load(FUNC_UNUSED, $urandom);
      end
      if (second_q.size() == 0 || (first_q.size() != 0 && $urandom_range(1))) begin
        load(msa_pkg::FUNC_LOAD_FIRST, first_q.pop_front());
      end else begin
        load(msa_pkg::FUNC_LOAD_SECOND, second_q.pop_front());
      end
    end
    load(msa_pkg::FUNC_COMPUTE, $urandom);
  endtask

  initial begin
    sb = new();
    start_i = 1'b0;
    cmd_i = '0;
    rst_ni = 1'b0;
    items_sent = 0;
    idle_pct = 0;
    quiet = 1'b0;
    full_done = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    load(msa_pkg::FUNC_COMPUTE, 32'sh7fff_ffff);
    load(msa_pkg::FUNC_LOAD_FIRST, 32'sh7fff_ffff);
    load(msa_pkg::FUNC_COMPUTE, 0);
    load(msa_pkg::FUNC_LOAD_SECOND, 32'sh8000_0000);
    load(msa_pkg::FUNC_LOAD_SECOND, 32'sh8000_0000);
    load(msa_pkg::FUNC_COMPUTE, 0);
    load(msa_pkg::FUNC_LOAD_FIRST, 32'sh8000_0000);
    load(msa_pkg::FUNC_LOAD_SECOND, 32'sh7fff_ffff);
    load(msa_pkg::FUNC_COMPUTE, -1);
    load(FUNC_UNUSED, -1);
    load(msa_pkg::FUNC_COMPUTE, 0);
    load(msa_pkg::FUNC_LOAD_FIRST, 1);
    load(msa_pkg::FUNC_LOAD_FIRST, 2);
    load(msa_pkg::FUNC_LOAD_FIRST, 3);
    load(msa_pkg::FUNC_LOAD_FIRST, 4);
    load(msa_pkg::FUNC_COMPUTE, 0);
    load(msa_pkg::FUNC_LOAD_SECOND, 9);
    load(msa_pkg::FUNC_LOAD_SECOND, -3);
    load(msa_pkg::FUNC_LOAD_FIRST, 4);
    load(msa_pkg::FUNC_COMPUTE, 0);

    while (items_sent < TOTAL_ITEMS) begin
      case ($urandom_range(2))
        0: idle_pct = 0;
        1: idle_pct = 10;
        default: idle_pct = 40;
      endcase
      if (!full_done && items_sent >= 200) begin
        if ($urandom_range(1)) begin
          run_set(msa_pkg::ARRAY_DEPTH + $urandom_range(1, 3), $urandom_range(8), 1'b1);
        end else begin
          run_set($urandom_range(8), msa_pkg::ARRAY_DEPTH + $urandom_range(1, 3), 1'b1);
        end
        full_done = 1'b1;
      end else if ($urandom_range(9) == 0) begin
        run_set($urandom_range(40), $urandom_range(40), $urandom_range(9) != 0);
      end else begin
        run_set($urandom_range(6), $urandom_range(6), $urandom_range(9) != 0);
      end
    end

    @(negedge clk_i);
    start_i = 1'b0;
    while (sb.expected_medians.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (sb.mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
